[rtl/core/fpe_pkg.sv]
// Shared widths, link structs and helpers for the frustum plane extractor.
// No dependencies; imported by fpe_div, fpe_sqrt and frustum_plane_extract_top.
package fpe_pkg;

    localparam int COEF_W      = 34;  // w +/- r of two 32-bit elements, with margin
    localparam int MAG_W       = 33;  // magnitude of a coefficient
    localparam int SC_W        = 31;  // scaled normal magnitude, top bit at 30
    localparam int NORM_BITS   = 30;
    localparam int OFF_FRAC    = 16;
    localparam int OFF_W       = 48;
    localparam int NUM_W       = 80;  // dividend: |d| << (16 + 30) at most
    localparam int DEN_W       = 34;  // len << rsh
    localparam int RAD_W       = 64;
    localparam int ROOT_W      = 32;
    localparam int PLANE_COUNT = 6;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] radicand;
    } t_sqrt_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_sqrt_rsp;

    // matrix row paired with row four for each plane
    function automatic logic [1:0] row_of_plane(logic [2:0] p);
        return p[2] ? 2'd2 : (p[1] ? 2'd1 : 2'd0);
    endfunction

    // 1 where the plane is row four minus the row
    function automatic logic sub_of_plane(logic [2:0] p);
        return (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
    endfunction

    function automatic logic [MAG_W-1:0] mag_of(logic signed [COEF_W-1:0] v);
        logic [COEF_W-1:0] u;
        u = v[COEF_W-1] ? COEF_W'(-v) : COEF_W'(v);
        return u[MAG_W-1:0];
    endfunction

endpackage

[rtl/core/frustum_plane_extract_top.sv]
// Frustum plane extractor: matrix store, plane sequencer, output register.
// Depends on fpe_pkg, fpe_div and fpe_sqrt.
//
// Input channel (i_elem_valid / o_elem_ready): one matrix element per transfer,
// with its storage slot. Slots 0..14 are only stored.
// A transfer to slot 15 stores it and starts a run over the six planes:
// left, right, top, bottom, near, far, delivered on the plane channel
// (o_plane_valid / i_plane_ready) with o_last_plane on the far plane.
// All sixteen slots must be written after reset before the first run.
// Per plane: store reads, a compare, the normalizing shift, scale and square,
// the square root, four passes through the shared divider (three normals, then
// the offset) and the load of the output register; a zero normal goes from the
// compare straight to the output register.
// o_elem_ready is low for the whole run. A finished plane sits in the
// output register; the next plane is computed meanwhile and waits until
// that register is taken, so a stalled receiver just holds the run.
// After the sixth plane is loaded the block takes elements again.
// Reset (synchronous, active low) clears sequencer and handshake state;
// the matrix store keeps no reset.
module frustum_plane_extract_top #(
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_elem_valid,
    output logic               o_elem_ready,
    input  logic signed [31:0] i_element_value,
    input  logic        [3:0]  i_element_slot,
    output logic               o_plane_valid,
    input  logic               i_plane_ready,
    output logic        [2:0]  o_plane_number,
    output logic signed [31:0] o_normal_x,
    output logic signed [31:0] o_normal_y,
    output logic signed [31:0] o_normal_z,
    output logic signed [47:0] o_plane_offset,
    output logic               o_degenerate,
    output logic               o_last_plane
);
    import fpe_pkg::*;

    localparam int EW_USE = (ELEMENT_WIDTH < 32) ? ELEMENT_WIDTH : 32;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RD    = 4'd1;
    localparam logic [3:0] ST_MAG   = 4'd2;
    localparam logic [3:0] ST_NORM  = 4'd3;
    localparam logic [3:0] ST_SCALE = 4'd4;
    localparam logic [3:0] ST_SQR   = 4'd5;
    localparam logic [3:0] ST_SQS   = 4'd6;
    localparam logic [3:0] ST_SQW   = 4'd7;
    localparam logic [3:0] ST_DVS   = 4'd8;
    localparam logic [3:0] ST_DVW   = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    // matrix store, registered read
    logic signed [ELEMENT_WIDTH-1:0] r_store [16];
    logic signed [ELEMENT_WIDTH-1:0] r_rd_data;
    logic        [3:0]               rd_addr;
    logic signed [EW_USE-1:0]        wr_lo;
    logic signed [ELEMENT_WIDTH-1:0] wr_val;
    logic                            in_xfer;
    logic signed [47:0]              rd48;

    assign in_xfer = i_elem_valid && o_elem_ready;
    assign wr_lo   = i_element_value[EW_USE-1:0];
    assign wr_val  = ELEMENT_WIDTH'(wr_lo);

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_store[i_element_slot] <= wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_store[rd_addr];
    end

    assign rd48 = 48'(r_rd_data);

    // sequencer state
    logic [3:0]                r_state, n_state;
    logic [2:0]                r_plane, n_plane;
    logic [3:0]                r_cnt, n_cnt;
    logic [1:0]                r_dc, n_dc;
    logic signed [COEF_W-1:0]  r_w, n_w;
    logic signed [COEF_W-1:0]  r_co [4];
    logic signed [COEF_W-1:0]  n_co [4];
    logic [MAG_W-1:0]          r_t, n_t;
    logic [4:0]                r_lsh, n_lsh;
    logic [1:0]                r_rsh, n_rsh;
    logic                      r_deg, n_deg;
    logic [SC_W-1:0]           r_mg [3];
    logic [SC_W-1:0]           n_mg [3];
    logic [2*SC_W-1:0]         r_prod, n_prod;
    logic [RAD_W-1:0]          r_sum, n_sum;
    logic [ROOT_W-1:0]         r_len, n_len;
    logic signed [31:0]        r_nrm [3];
    logic signed [31:0]        n_nrm [3];
    logic signed [OFF_W-1:0]   r_off, n_off;

    // output register
    logic               r_o_valid, n_o_valid;
    logic [2:0]         r_o_num, n_o_num;
    logic signed [31:0] r_o_x, n_o_x, r_o_y, n_o_y, r_o_z, n_o_z;
    logic signed [47:0] r_o_off, n_o_off;
    logic               r_o_deg, n_o_deg, r_o_last, n_o_last;

    t_div_req  div_req;
    t_div_rsp  div_rsp;
    t_sqrt_req sq_req;
    t_sqrt_rsp sq_rsp;

    fpe_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));
    fpe_sqrt u_sqrt (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(sq_req), .o_rsp(sq_rsp));

    logic [MAG_W-1:0]   mag [3];
    logic [MAG_W-1:0]   top01, top;
    logic [MAG_W-1:0]   dmag;
    logic [2:0]         rd_step;
    logic [SC_W-1:0]    sq_op;
    logic [OFF_W-1:0]   q_off;
    logic [31:0]        q_nrm;
    logic               off_neg, off_sat;
    logic               out_free;

    assign rd_addr = {r_cnt[2:1], r_cnt[0] ? row_of_plane(r_plane) : 2'd3};
    assign rd_step = 3'(r_cnt - 4'd1);
    assign out_free = !r_o_valid || i_plane_ready;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            mag[c] = mag_of(r_co[c]);
        end
        top01 = (mag[1] > mag[0]) ? mag[1] : mag[0];
        top   = (mag[2] > top01) ? mag[2] : top01;
        dmag  = mag_of(r_co[3]);
        sq_op = (r_cnt[1:0] == 2'd0) ? r_mg[0] : ((r_cnt[1:0] == 2'd1) ? r_mg[1] : r_mg[2]);
    end

    // divider operands by step: three normal components, then the offset
    always_comb begin
        div_req.start = (r_state == ST_DVS);
        if (r_dc == 2'd3) begin
            div_req.num = NUM_W'(dmag) << (OFF_FRAC + int'(r_lsh));
            div_req.den = DEN_W'(r_len) << r_rsh;
        end else begin
            div_req.num = NUM_W'({r_mg[r_dc], NORM_BITS'(0)});
            div_req.den = DEN_W'(r_len);
        end
        sq_req.start    = (r_state == ST_SQS);
        sq_req.radicand = r_sum;
    end

    // saturation of the quotient
    always_comb begin
        q_nrm   = (div_rsp.quot[NUM_W-1:31] != '0) ? 32'h7FFF_FFFF : div_rsp.quot[31:0];
        off_neg = r_co[3][COEF_W-1];
        if (off_neg) begin
            off_sat = (div_rsp.quot[NUM_W-1:OFF_W] != '0)
                   || (div_rsp.quot[OFF_W-1] && (div_rsp.quot[OFF_W-2:0] != '0));
        end else begin
            off_sat = (div_rsp.quot[NUM_W-1:OFF_W-1] != '0);
        end
        if (off_sat) begin
            q_off = off_neg ? (OFF_W'(1) << (OFF_W - 1)) : ((OFF_W'(1) << (OFF_W - 1)) - 1'b1);
        end else begin
            q_off = div_rsp.quot[OFF_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_plane = r_plane;
        n_cnt   = r_cnt;
        n_dc    = r_dc;
        n_w     = r_w;
        n_co    = r_co;
        n_t     = r_t;
        n_lsh   = r_lsh;
        n_rsh   = r_rsh;
        n_deg   = r_deg;
        n_mg    = r_mg;
        n_prod  = r_prod;
        n_sum   = r_sum;
        n_len   = r_len;
        n_nrm   = r_nrm;
        n_off   = r_off;

        n_o_valid = (r_o_valid && !i_plane_ready);
        n_o_num   = r_o_num;
        n_o_x     = r_o_x;
        n_o_y     = r_o_y;
        n_o_z     = r_o_z;
        n_o_off   = r_o_off;
        n_o_deg   = r_o_deg;
        n_o_last  = r_o_last;

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && (i_element_slot == 4'd15)) begin
                    n_state = ST_RD;
                    n_plane = '0;
                    n_cnt   = '0;
                end
            end
            ST_RD: begin
                // address for step cnt goes out now; data of step cnt-1 is back
                if (r_cnt != 4'd0) begin
                    if (!rd_step[0]) begin
                        n_w = $signed(rd48[COEF_W-1:0]);
                    end else begin
                        n_co[rd_step[2:1]] = sub_of_plane(r_plane)
                            ? COEF_W'(r_w - $signed(rd48[COEF_W-1:0]))
                            : COEF_W'(r_w + $signed(rd48[COEF_W-1:0]));
                    end
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 4'd8) begin
                    n_state = ST_MAG;
                end
            end
            ST_MAG: begin
                n_t   = top;
                n_lsh = '0;
                n_rsh = '0;
                n_deg = (top == '0);
                n_state = (top == '0) ? ST_OUT : ST_NORM;
            end
            ST_NORM: begin
                // bring the largest magnitude's top bit to bit 30
                if (r_t[32]) begin
                    n_rsh   = 2'd2;
                    n_state = ST_SCALE;
                end else if (r_t[31]) begin
                    n_rsh   = 2'd1;
                    n_state = ST_SCALE;
                end else if (r_t[30]) begin
                    n_state = ST_SCALE;
                end else begin
                    n_t   = {r_t[MAG_W-2:0], 1'b0};
                    n_lsh = r_lsh + 1'b1;
                end
            end
            ST_SCALE: begin
                for (int c = 0; c < 3; c++) begin
                    n_mg[c] = (r_lsh != '0) ? SC_W'(mag[c] << r_lsh) : SC_W'(mag[c] >> r_rsh);
                end
                n_sum   = '0;
                n_cnt   = '0;
                n_state = ST_SQR;
            end
            ST_SQR: begin
                if (r_cnt != 4'd3) begin
                    n_prod = sq_op * sq_op;
                end
                if (r_cnt != 4'd0) begin
                    n_sum = r_sum + RAD_W'(r_prod);
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 4'd3) begin
                    n_state = ST_SQS;
                end
            end
            ST_SQS: begin
                n_state = ST_SQW;
            end
            ST_SQW: begin
                if (sq_rsp.done) begin
                    n_len   = sq_rsp.root;
                    n_dc    = '0;
                    n_state = ST_DVS;
                end
            end
            ST_DVS: begin
                n_state = ST_DVW;
            end
            ST_DVW: begin
                if (div_rsp.done) begin
                    if (r_dc == 2'd3) begin
                        n_off   = off_neg ? OFF_W'(-q_off) : q_off;
                        n_state = ST_OUT;
                    end else begin
                        n_nrm[r_dc] = r_co[r_dc][COEF_W-1] ? 32'(-q_nrm) : q_nrm;
                        n_dc        = r_dc + 1'b1;
                        n_state     = ST_DVS;
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_num   = r_plane;
                    n_o_x     = r_deg ? '0 : r_nrm[0];
                    n_o_y     = r_deg ? '0 : r_nrm[1];
                    n_o_z     = r_deg ? '0 : r_nrm[2];
                    n_o_off   = r_deg ? '0 : r_off;
                    n_o_deg   = r_deg;
                    n_o_last  = (r_plane == 3'(PLANE_COUNT - 1));
                    n_cnt     = '0;
                    if (r_plane == 3'(PLANE_COUNT - 1)) begin
                        n_plane = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_plane = r_plane + 1'b1;
                        n_state = ST_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_plane   <= '0;
            r_cnt     <= '0;
            r_dc      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_plane   <= n_plane;
            r_cnt     <= n_cnt;
            r_dc      <= n_dc;
            r_o_valid <= n_o_valid;
        end
        r_w      <= n_w;
        r_co     <= n_co;
        r_t      <= n_t;
        r_lsh    <= n_lsh;
        r_rsh    <= n_rsh;
        r_deg    <= n_deg;
        r_mg     <= n_mg;
        r_prod   <= n_prod;
        r_sum    <= n_sum;
        r_len    <= n_len;
        r_nrm    <= n_nrm;
        r_off    <= n_off;
        r_o_num  <= n_o_num;
        r_o_x    <= n_o_x;
        r_o_y    <= n_o_y;
        r_o_z    <= n_o_z;
        r_o_off  <= n_o_off;
        r_o_deg  <= n_o_deg;
        r_o_last <= n_o_last;
    end

    assign o_elem_ready   = (r_state == ST_IDLE);
    assign o_plane_valid  = r_o_valid;
    assign o_plane_number = r_o_num;
    assign o_normal_x     = r_o_x;
    assign o_normal_y     = r_o_y;
    assign o_normal_z     = r_o_z;
    assign o_plane_offset = r_o_off;
    assign o_degenerate   = r_o_deg;
    assign o_last_plane   = r_o_last;

endmodule

[rtl/core/fpe_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on fpe_pkg.
module fpe_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fpe_pkg::t_div_req i_req,
    output fpe_pkg::t_div_rsp o_rsp
);
    import fpe_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0] r_num, n_num;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [DEN_W:0]   trial;

    assign trial = {r_rem, r_num[NUM_W-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_num  = i_req.num;
            n_rem  = '0;
            n_den  = i_req.den;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = DEN_W'(trial - {1'b0, r_den});
                n_num = {r_num[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DEN_W-1:0];
                n_num = {r_num[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;

endmodule

[rtl/core/fpe_sqrt.sv]
// Integer square root, two radicand bits per cycle.
// Depends on fpe_pkg.
module fpe_sqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fpe_pkg::t_sqrt_req i_req,
    output fpe_pkg::t_sqrt_rsp o_rsp
);
    import fpe_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [RAD_W-1:0] r_s, n_s;
    logic [RAD_W-1:0] r_res, n_res;
    logic [RAD_W-1:0] r_bit, n_bit;
    logic [RAD_W-1:0] trial;

    assign trial = r_res + r_bit;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_s    = r_s;
        n_res  = r_res;
        n_bit  = r_bit;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_s    = i_req.radicand;
            n_res  = '0;
            n_bit  = RAD_W'(1) << (RAD_W - 2);
        end else if (r_busy) begin
            if (r_s >= trial) begin
                n_s   = r_s - trial;
                n_res = (r_res >> 1) + r_bit;
            end else begin
                n_res = r_res >> 1;
            end
            n_bit = r_bit >> 2;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_s   <= n_s;
        r_res <= n_res;
        r_bit <= n_bit;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_res[ROOT_W-1:0];

endmodule
